// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the triangle normal datapath.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define TNC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define TNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tnc_pkg.sv =====
// ----------------------------------------------------------------------------
// tnc_pkg
// Widths, constants and beat types of the triangle normal/centroid datapath.
// ----------------------------------------------------------------------------
package tnc_pkg;

  localparam int CoordW   = 16;
  localparam int NormOne  = 16384;
  localparam int FracBits = 14;
  localparam int Recip3   = 43691;  // ceil(2^17 / 3)
  localparam int RecipSh  = 17;
  localparam int DW       = 31;     // normalized magnitude width
  localparam int SumW     = 64;
  localparam int RootW    = 32;
  localparam int RemW     = 36;
  localparam int QW       = 16;     // quotient bits
  localparam int NumSqCells  = RootW;
  localparam int NumDivCells = QW;

  typedef struct packed {
    logic [2:0]               neg;
    logic                     degen;
    logic signed [CoordW-1:0] cen_x;
    logic signed [CoordW-1:0] cen_y;
    logic signed [CoordW-1:0] cen_z;
  } tnc_side_t;

  // beat moving down the square-root row
  typedef struct packed {
    logic [SumW-1:0]       s;
    logic [RemW-1:0]       rem;
    logic [RootW-1:0]      root;
    logic [2:0][DW-1:0]    d;
    tnc_side_t             side;
  } tnc_sq_t;

  // beat moving down the divider row, three lanes
  typedef struct packed {
    logic [RootW-1:0]        len;
    logic [2:0][RootW-1:0]   r;
    logic [2:0][QW-1:0]      nlo;
    logic [2:0][QW-1:0]      q;
    tnc_side_t               side;
  } tnc_dv_t;

endpackage

// ===== rtl/core/tnc_front.sv =====
// ----------------------------------------------------------------------------
// tnc_front
// Edges, cross product, centroid, normalizing shift, squared length.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tnc_front
  import tnc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CoordW-1:0] in_ax,
  input  logic signed [CoordW-1:0] in_ay,
  input  logic signed [CoordW-1:0] in_az,
  input  logic signed [CoordW-1:0] in_bx,
  input  logic signed [CoordW-1:0] in_by,
  input  logic signed [CoordW-1:0] in_bz,
  input  logic signed [CoordW-1:0] in_cx,
  input  logic signed [CoordW-1:0] in_cy,
  input  logic signed [CoordW-1:0] in_cz,
  output logic                     out_valid,
  input  logic                     out_ready,
  output tnc_sq_t                  out_data
);

  localparam int NStg = 7;

  logic [NStg-1:0] v_r;
  logic [NStg-1:0] ld;

  // stage 0: edges and axis sums
  logic signed [16:0] e1_r [3];
  logic signed [16:0] e2_r [3];
  logic signed [17:0] sm_r [3];
  // stage 1: products and centroid scaling
  logic signed [33:0] p_r [6];
  logic [33:0]        cp_r [3];
  logic [2:0]         cs_r;
  // stage 2: cross product magnitudes
  logic [33:0]        mag2_r [3];
  tnc_side_t          side2_r;
  // stage 3: shift amount
  logic [33:0]        mag3_r [3];
  tnc_side_t          side3_r;
  logic               rgt_r;
  logic [1:0]         rsh_r;
  logic [4:0]         lsh_r;
  // stage 4..6
  logic [DW-1:0]      d4_r [3];
  tnc_side_t          side4_r;
  logic [61:0]        sq5_r [3];
  logic [DW-1:0]      d5_r [3];
  tnc_side_t          side5_r;
  logic [SumW-1:0]    sum6_r;
  logic [DW-1:0]      d6_r [3];
  tnc_side_t          side6_r;

  always_comb begin
    ld[NStg-1] = !v_r[NStg-1] || out_ready;
    for (int i = NStg - 2; i >= 0; i--) begin
      ld[i] = !v_r[i] || ld[i+1];
    end
  end

  assign in_ready = ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NStg; i++) begin
        if (ld[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // stage 0
  logic signed [16:0] e1_nxt [3];
  logic signed [16:0] e2_nxt [3];
  logic signed [17:0] sm_nxt [3];
  always_comb begin
    e1_nxt[0] = 17'($signed(in_bx)) - 17'($signed(in_ax));
    e1_nxt[1] = 17'($signed(in_by)) - 17'($signed(in_ay));
    e1_nxt[2] = 17'($signed(in_bz)) - 17'($signed(in_az));
    e2_nxt[0] = 17'($signed(in_cx)) - 17'($signed(in_bx));
    e2_nxt[1] = 17'($signed(in_cy)) - 17'($signed(in_by));
    e2_nxt[2] = 17'($signed(in_cz)) - 17'($signed(in_bz));
    sm_nxt[0] = 18'($signed(in_ax)) + 18'($signed(in_bx)) + 18'($signed(in_cx));
    sm_nxt[1] = 18'($signed(in_ay)) + 18'($signed(in_by)) + 18'($signed(in_cy));
    sm_nxt[2] = 18'($signed(in_az)) + 18'($signed(in_bz)) + 18'($signed(in_cz));
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      e1_r <= e1_nxt;
      e2_r <= e2_nxt;
      sm_r <= sm_nxt;
    end
  end

  // stage 1
  logic [16:0] sabs [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sabs[i] = sm_r[i][17] ? 17'(-sm_r[i]) : 17'(sm_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      p_r[0] <= e1_r[1] * e2_r[2];
      p_r[1] <= e1_r[2] * e2_r[1];
      p_r[2] <= e1_r[2] * e2_r[0];
      p_r[3] <= e1_r[0] * e2_r[2];
      p_r[4] <= e1_r[0] * e2_r[1];
      p_r[5] <= e1_r[1] * e2_r[0];
      for (int i = 0; i < 3; i++) begin
        cp_r[i] <= 34'(sabs[i]) * 34'(Recip3);
        cs_r[i] <= sm_r[i][17];
      end
    end
  end

  // stage 2
  logic signed [34:0] xc [3];
  logic [33:0]        mag_nxt [3];
  logic [16:0]        cq [3];
  logic [CoordW-1:0]  cen [3];
  tnc_side_t          side2_nxt;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xc[i] = 35'(p_r[2*i]) - 35'(p_r[2*i+1]);
      mag_nxt[i] = xc[i][34] ? 34'(-xc[i]) : 34'(xc[i]);
      cq[i] = cp_r[i][33:RecipSh];
      cen[i] = cs_r[i] ? 16'(-cq[i]) : cq[i][15:0];
    end
    side2_nxt.neg   = {xc[2][34], xc[1][34], xc[0][34]};
    side2_nxt.degen = 1'b0;
    side2_nxt.cen_x = cen[0];
    side2_nxt.cen_y = cen[1];
    side2_nxt.cen_z = cen[2];
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      mag2_r  <= mag_nxt;
      side2_r <= side2_nxt;
    end
  end

  // stage 3: leading one of the largest magnitude
  logic [33:0] orw;
  logic [5:0]  pos;
  tnc_side_t   side3_nxt;
  always_comb begin
    orw = mag2_r[0] | mag2_r[1] | mag2_r[2];
    pos = '0;
    for (int i = 0; i < 34; i++) begin
      if (orw[i]) pos = 6'(i);
    end
    side3_nxt       = side2_r;
    side3_nxt.degen = (orw == '0);
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      mag3_r  <= mag2_r;
      side3_r <= side3_nxt;
      rgt_r   <= (pos > 6'd30);
      rsh_r   <= 2'(pos - 6'd30);
      lsh_r   <= 5'(6'd30 - pos);
    end
  end

  // stage 4: apply shift so the largest lands in [2^30, 2^31)
  logic [33:0] sh [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = rgt_r ? (mag3_r[i] >> rsh_r) : (mag3_r[i] << lsh_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      for (int i = 0; i < 3; i++) d4_r[i] <= sh[i][DW-1:0];
      side4_r <= side3_r;
    end
  end

  // stage 5: squares
  always_ff @(posedge clk) begin
    if (ld[5]) begin
      for (int i = 0; i < 3; i++) sq5_r[i] <= 62'(d4_r[i]) * 62'(d4_r[i]);
      d5_r    <= d4_r;
      side5_r <= side4_r;
    end
  end

  // stage 6: sum of squares
  always_ff @(posedge clk) begin
    if (ld[6]) begin
      sum6_r  <= 64'(sq5_r[0]) + 64'(sq5_r[1]) + 64'(sq5_r[2]);
      d6_r    <= d5_r;
      side6_r <= side5_r;
    end
  end

  assign out_valid = v_r[NStg-1];

  always_comb begin
    out_data.s    = sum6_r;
    out_data.rem  = '0;
    out_data.root = '0;
    for (int i = 0; i < 3; i++) out_data.d[i] = d6_r[i];
    out_data.side = side6_r;
  end

  `TNC_ASSERT_IMPL(a_front_degen_zero, clk, rst_n,
    v_r[NStg-1] && side6_r.degen, sum6_r == '0, "degenerate beat with nonzero length")

endmodule

// ===== rtl/core/tnc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tnc_sqrt_cell
// One root bit of the integer square root; hands the beat on each cycle unless the next cell stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tnc_sqrt_cell
  import tnc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  tnc_sq_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output tnc_sq_t out_data
);

  logic    v_r;
  tnc_sq_t data_r;
  tnc_sq_t data_nxt;
  logic [RemW-1:0] rs;
  logic [RemW-1:0] t;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    data_nxt = in_data;
    rs = {in_data.rem[RemW-3:0], in_data.s[SumW-1 -: 2]};
    t  = {2'b00, in_data.root, 2'b01};
    data_nxt.s = {in_data.s[SumW-3:0], 2'b00};
    if (rs >= t) begin
      data_nxt.rem  = rs - t;
      data_nxt.root = {in_data.root[RootW-2:0], 1'b1};
    end else begin
      data_nxt.rem  = rs;
      data_nxt.root = {in_data.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) data_r <= data_nxt;
  end

  assign out_valid = v_r;
  assign out_data  = data_r;

  // remainder never exceeds twice the partial root
  `TNC_ASSERT_IMPL(a_sqrt_rem_bound, clk, rst_n,
    v_r, data_r.rem <= {3'b000, data_r.root, 1'b0}, "sqrt remainder out of range")

endmodule

// ===== rtl/core/tnc_div_cell.sv =====
// ----------------------------------------------------------------------------
// tnc_div_cell
// One quotient bit of the three-lane restoring divide by the length.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tnc_div_cell
  import tnc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  tnc_dv_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output tnc_dv_t out_data
);

  logic    v_r;
  tnc_dv_t data_r;
  tnc_dv_t data_nxt;
  logic [RootW:0] rs [3];
  logic [RootW:0] df [3];

  assign in_ready = !v_r || out_ready;

  always_comb begin
    data_nxt = in_data;
    for (int i = 0; i < 3; i++) begin
      rs[i] = {in_data.r[i], in_data.nlo[i][QW-1]};
      df[i] = rs[i] - {1'b0, in_data.len};
      data_nxt.nlo[i] = {in_data.nlo[i][QW-2:0], 1'b0};
      if (rs[i] >= {1'b0, in_data.len}) begin
        data_nxt.r[i] = df[i][RootW-1:0];
        data_nxt.q[i] = {in_data.q[i][QW-2:0], 1'b1};
      end else begin
        data_nxt.r[i] = rs[i][RootW-1:0];
        data_nxt.q[i] = {in_data.q[i][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) data_r <= data_nxt;
  end

  assign out_valid = v_r;
  assign out_data  = data_r;

  `TNC_ASSERT_IMPL(a_div_rem_bound, clk, rst_n,
    v_r && !data_r.side.degen,
    data_r.r[0] < data_r.len && data_r.r[1] < data_r.len && data_r.r[2] < data_r.len,
    "divider partial remainder not below length")

endmodule

// ===== rtl/core/triangle_normal_and_centroid.sv =====
// ----------------------------------------------------------------------------
// triangle_normal_and_centroid
// Unit face normal (Q1.14) and centroid (Q8.8) of one triangle per beat.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  in_       in   in_valid/in_ready    ax..cz, 16b signed Q8.8
//  out_      out  out_valid/out_ready  normal_x/y/z Q1.14, centroid_x/y/z, degenerate
//
//  One beat per cycle sustained while out_ready holds; 7 front stages, 32 root
//  cells (one root bit each), 16 divider cells (one quotient bit each), 1 output.
//  Every stage has its own valid bit, so bubbles close up under a stall and
//  the input keeps taking beats until the whole row is full.
//  Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_normal_and_centroid
  import tnc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CoordW-1:0] in_ax,
  input  logic signed [CoordW-1:0] in_ay,
  input  logic signed [CoordW-1:0] in_az,
  input  logic signed [CoordW-1:0] in_bx,
  input  logic signed [CoordW-1:0] in_by,
  input  logic signed [CoordW-1:0] in_bz,
  input  logic signed [CoordW-1:0] in_cx,
  input  logic signed [CoordW-1:0] in_cy,
  input  logic signed [CoordW-1:0] in_cz,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [CoordW-1:0] out_normal_x,
  output logic signed [CoordW-1:0] out_normal_y,
  output logic signed [CoordW-1:0] out_normal_z,
  output logic signed [CoordW-1:0] out_centroid_x,
  output logic signed [CoordW-1:0] out_centroid_y,
  output logic signed [CoordW-1:0] out_centroid_z,
  output logic                     out_degenerate
);

  logic    sq_v   [NumSqCells+1];
  logic    sq_rdy [NumSqCells+1];
  tnc_sq_t sq_d   [NumSqCells+1];

  logic    dv_v   [NumDivCells+1];
  logic    dv_rdy [NumDivCells+1];
  tnc_dv_t dv_d   [NumDivCells+1];

  tnc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_ax     (in_ax),
    .in_ay     (in_ay),
    .in_az     (in_az),
    .in_bx     (in_bx),
    .in_by     (in_by),
    .in_bz     (in_bz),
    .in_cx     (in_cx),
    .in_cy     (in_cy),
    .in_cz     (in_cz),
    .out_valid (sq_v[0]),
    .out_ready (sq_rdy[0]),
    .out_data  (sq_d[0])
  );

  for (genvar k = 0; k < NumSqCells; k++) begin : g_sq
    tnc_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[k]),
      .in_ready  (sq_rdy[k]),
      .in_data   (sq_d[k]),
      .out_valid (sq_v[k+1]),
      .out_ready (sq_rdy[k+1]),
      .out_data  (sq_d[k+1])
    );
  end

  // divider entry: numerator = d * 2^14 + len / 2, top bits seed the remainder
  logic [45:0] num [3];
  always_comb begin
    dv_d[0].len  = sq_d[NumSqCells].root;
    dv_d[0].side = sq_d[NumSqCells].side;
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, sq_d[NumSqCells].d[i], {FracBits{1'b0}}}
             + {15'd0, sq_d[NumSqCells].root[RootW-1:1]};
      dv_d[0].r[i]   = {2'b00, num[i][45:QW]};
      dv_d[0].nlo[i] = num[i][QW-1:0];
      dv_d[0].q[i]   = '0;
    end
  end
  assign dv_v[0] = sq_v[NumSqCells];
  assign sq_rdy[NumSqCells] = dv_rdy[0];

  for (genvar k = 0; k < NumDivCells; k++) begin : g_dv
    tnc_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_v[k]),
      .in_ready  (dv_rdy[k]),
      .in_data   (dv_d[k]),
      .out_valid (dv_v[k+1]),
      .out_ready (dv_rdy[k+1]),
      .out_data  (dv_d[k+1])
    );
  end

  // output register: clamp, sign, degenerate override
  logic              ov_r;
  logic              ld;
  logic [QW-1:0]     qc [3];
  logic [CoordW-1:0] n_nxt [3];
  logic [CoordW-1:0] n_r [3];
  tnc_side_t         side_r;

  assign ld = !ov_r || out_ready;
  assign dv_rdy[NumDivCells] = ld;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_d[NumDivCells].q[i] > QW'(NormOne)) ? QW'(NormOne)
            : dv_d[NumDivCells].q[i];
      if (dv_d[NumDivCells].side.degen) begin
        n_nxt[i] = '0;
      end else if (dv_d[NumDivCells].side.neg[i]) begin
        n_nxt[i] = ~qc[i] + 1'b1;
      end else begin
        n_nxt[i] = qc[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ld) begin
      ov_r <= dv_v[NumDivCells];
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      n_r    <= n_nxt;
      side_r <= dv_d[NumDivCells].side;
    end
  end

  assign out_valid      = ov_r;
  assign out_normal_x   = n_r[0];
  assign out_normal_y   = n_r[1];
  assign out_normal_z   = n_r[2];
  assign out_centroid_x = side_r.cen_x;
  assign out_centroid_y = side_r.cen_y;
  assign out_centroid_z = side_r.cen_z;
  assign out_degenerate = side_r.degen;

  `TNC_ASSERT_IMPL(a_degen_normal_zero, clk, rst_n,
    out_valid && out_degenerate,
    out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0,
    "degenerate result carries a nonzero normal")

  `TNC_ASSERT_IMPL(a_normal_range, clk, rst_n,
    out_valid,
    out_normal_x >= -16'sd16384 && out_normal_x <= 16'sd16384 &&
    out_normal_y >= -16'sd16384 && out_normal_y <= 16'sd16384 &&
    out_normal_z >= -16'sd16384 && out_normal_z <= 16'sd16384,
    "normal component beyond unit range")

  `TNC_ASSERT_NEXT(a_out_drain, clk, rst_n,
    out_valid && out_ready && !dv_v[NumDivCells], !out_valid,
    "output beat repeated")

endmodule
